/* rtl/core/tkud_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkud_pkg
// Shared key kinds, byte constants and result types for the terminal key
// UTF-8 decoder.
// ----------------------------------------------------------------------------
package tkud_pkg;

  localparam logic [2:0] KIND_CHAR      = 3'd0;
  localparam logic [2:0] KIND_ENTER     = 3'd1;
  localparam logic [2:0] KIND_BACKSPACE = 3'd2;
  localparam logic [2:0] KIND_ESCAPE    = 3'd3;
  localparam logic [2:0] KIND_UNSUPP    = 3'd4;
  localparam logic [2:0] KIND_BAD_LEAD  = 3'd5;
  localparam logic [2:0] KIND_BAD_TRAIL = 3'd6;
  localparam logic [2:0] KIND_OVERLONG  = 3'd7;

  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_SP  = 8'h20;

  localparam logic [20:0] LIMIT_2 = 21'h000080;
  localparam logic [20:0] LIMIT_3 = 21'h000800;
  localparam logic [20:0] LIMIT_4 = 21'h010000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] cp;
  } result_t;

  typedef struct packed {
    logic    has_result;
    result_t res;
  } step_t;

endpackage

/* rtl/core/terminal_key_utf8_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_utf8_decoder_core
// Terminal byte stream to key words: UTF-8 decode with overlong check.
//
//   channel  signals                             dir
//   in       in_valid in_stall in_byte more_pending   sink
//   out      out_valid out_stall key_kind code_point   source
//   cfg      cfg_valid cfg_ready check_trailing        sink
//
// One byte per cycle sustained unless out stalls; a key word is loaded into the
// result register from the input register, through the decode logic.
// Reset clears the sequence state, both valid flags, and sets check_trailing.
// Bytes that finish no key advance even while out is stalled; a byte that
// finishes a key waits in the input register until the result register frees.
// ----------------------------------------------------------------------------
module terminal_key_utf8_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        more_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  key_kind,
  output logic [20:0] code_point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        check_trailing
);

  logic              chk;
  logic              in_reg_valid;
  logic [7:0]        byte_r;
  logic              more_r;
  logic              advance;
  logic              out_ready;
  tkud_pkg::step_t   step;
  tkud_pkg::result_t res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      chk <= check_trailing;
    end
  end

  assign advance  = in_reg_valid && (!step.has_result || out_ready);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
      more_r <= more_pending;
    end
  end

  tkud_step u_step (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .byte_in        (byte_r),
    .more           (more_r),
    .check_trailing (chk),
    .step           (step)
  );

  tkud_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step.has_result),
    .res_in    (step.res),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign key_kind   = res_out.kind;
  assign code_point = res_out.cp;

endmodule

/* rtl/core/tkud_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkud_step
// Sequence state and per-byte decode: lead bytes, continuation bytes,
// control keys and overlong check. State updates on advance.
// ----------------------------------------------------------------------------
module tkud_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         byte_in,
  input  logic               more,
  input  logic               check_trailing,
  output tkud_pkg::step_t    step
);

  logic [1:0]  bytes_left;
  logic [1:0]  seq_length;
  logic [20:0] partial_value;
  logic [1:0]  bytes_left_next;
  logic [1:0]  seq_length_next;
  logic [20:0] partial_value_next;

  logic [20:0] acc;
  logic [1:0]  left_dec;
  logic [20:0] limit;

  assign acc      = {partial_value[14:0], byte_in[5:0]};
  assign left_dec = bytes_left - 2'd1;

  always_comb begin
    unique case (seq_length)
      2'd3:    limit = tkud_pkg::LIMIT_4;
      2'd2:    limit = tkud_pkg::LIMIT_3;
      default: limit = tkud_pkg::LIMIT_2;
    endcase
  end

  always_comb begin
    bytes_left_next    = bytes_left;
    seq_length_next    = seq_length;
    partial_value_next = partial_value;
    step.has_result    = 1'b0;
    step.res.kind      = tkud_pkg::KIND_CHAR;
    step.res.cp        = '0;
    if (bytes_left != 2'd0) begin
      if (check_trailing && (byte_in[7:6] != 2'b10)) begin
        bytes_left_next    = 2'd0;
        seq_length_next    = 2'd0;
        partial_value_next = '0;
        step.has_result    = 1'b1;
        step.res.kind      = tkud_pkg::KIND_BAD_TRAIL;
      end else if (left_dec != 2'd0) begin
        bytes_left_next    = left_dec;
        partial_value_next = acc;
      end else begin
        bytes_left_next    = 2'd0;
        seq_length_next    = 2'd0;
        partial_value_next = '0;
        step.has_result    = 1'b1;
        if (acc < limit) begin
          step.res.kind = tkud_pkg::KIND_OVERLONG;
        end else begin
          step.res.cp = acc;
        end
      end
    end else begin
      step.has_result = 1'b1;
      priority if (byte_in == tkud_pkg::BYTE_LF) begin
        step.res.kind = tkud_pkg::KIND_ENTER;
      end else if (byte_in == tkud_pkg::BYTE_DEL || byte_in == tkud_pkg::BYTE_BS) begin
        step.res.kind = tkud_pkg::KIND_BACKSPACE;
      end else if (byte_in < tkud_pkg::BYTE_SP) begin
        if (!more && byte_in == tkud_pkg::BYTE_ESC) begin
          step.res.kind = tkud_pkg::KIND_ESCAPE;
        end else begin
          step.res.kind = tkud_pkg::KIND_UNSUPP;
        end
      end else if (byte_in[7:3] == 5'b11110) begin
        step.has_result    = 1'b0;
        bytes_left_next    = 2'd3;
        seq_length_next    = 2'd3;
        partial_value_next = {18'd0, byte_in[2:0]};
      end else if (byte_in[7:4] == 4'b1110) begin
        step.has_result    = 1'b0;
        bytes_left_next    = 2'd2;
        seq_length_next    = 2'd2;
        partial_value_next = {17'd0, byte_in[3:0]};
      end else if (byte_in[7:5] == 3'b110) begin
        step.has_result    = 1'b0;
        bytes_left_next    = 2'd1;
        seq_length_next    = 2'd1;
        partial_value_next = {16'd0, byte_in[4:0]};
      end else if (!byte_in[7]) begin
        step.res.cp = {13'd0, byte_in};
      end else begin
        step.res.kind = tkud_pkg::KIND_BAD_LEAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 2'd0;
      seq_length    <= 2'd0;
      partial_value <= '0;
    end else if (advance) begin
      bytes_left    <= bytes_left_next;
      seq_length    <= seq_length_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

/* rtl/core/tkud_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkud_out_reg
// One-word result register with valid/stall handshake toward the sink.
// ----------------------------------------------------------------------------
module tkud_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tkud_pkg::result_t   res_in,
  input  logic                out_stall,
  output logic                ready,
  output logic                out_valid,
  output tkud_pkg::result_t   res_out
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_out <= res_in;
    end
  end

endmodule

/* rtl/core/tkud_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkud_checker
// Port-level checks on the decoder outputs, bound to the top level.
// ----------------------------------------------------------------------------
module tkud_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  key_kind,
  input logic [20:0] code_point
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_kind) && $stable(code_point))
    else $error("stalled out word changed");

  a_cp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_kind != tkud_pkg::KIND_CHAR |-> code_point == 21'd0)
    else $error("non-char word carries a code point");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_kind == tkud_pkg::KIND_CHAR |-> code_point >= 21'h20
      && code_point != 21'h7F)
    else $error("char word holds a control code");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind terminal_key_utf8_decoder_core tkud_checker u_tkud_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .key_kind   (key_kind),
  .code_point (code_point)
);
